// ===== rtl/hss_pkg.sv =====
package hss_pkg;

   localparam int HEIGHT_BITS   = 16;
   localparam int SOBEL_BITS    = HEIGHT_BITS + 3;        // signed Sobel sum
   localparam int MAG_BITS      = HEIGHT_BITS + 2;        // |Sobel sum|
   localparam int SQR_BITS      = 2 * MAG_BITS;           // one square
   localparam int SQ_BITS       = SQR_BITS + 2;           // sum of squares plus u^2
   localparam int RAD_BITS      = SQ_BITS + 8;            // radicand, Q scaled by 256
   localparam int ROOT_BITS     = RAD_BITS / 2;
   localparam int SRM_BITS      = ROOT_BITS + 2;
   localparam int LDIR_BITS     = 10;
   localparam int PRD_BITS      = SOBEL_BITS + LDIR_BITS;
   localparam int NUM_BITS      = PRD_BITS + 1;
   localparam int DIV_SHIFT     = 11;
   localparam int DVD_BITS      = NUM_BITS - 1 + DIV_SHIFT;
   localparam int QUO_BITS      = 18;
   localparam int DREM_BITS     = ROOT_BITS + 1;
   localparam int LVL_BITS      = QUO_BITS + 1;
   localparam int LVLS_BITS     = QUO_BITS + 2;
   localparam int SUM_BITS      = HEIGHT_BITS + 3;
   localparam int STR_BITS      = 8;
   localparam int AOX_BITS      = SUM_BITS + STR_BITS;
   localparam int RCP_BITS      = AOX_BITS + 1;
   localparam int RPROD_BITS    = AOX_BITS + RCP_BITS;
   localparam int CNT_BITS      = 4;
   localparam int FLOOR_BITS    = 9;
   localparam int AO_BITS       = FLOOR_BITS + 8;
   localparam int AOD_BITS      = AOX_BITS + 2;
   localparam int INT_BITS      = 9;
   localparam int BOOST_BITS    = 9;
   localparam int THR_BITS      = 16;
   localparam int CMP_BITS      = (MAG_BITS > THR_BITS + 3) ? MAG_BITS : THR_BITS + 3;
   localparam int LEVEL_BITS    = 9;
   localparam int P1_BITS       = LVL_BITS + AO_BITS;
   localparam int P2_BITS       = P1_BITS + INT_BITS;
   localparam int P3_BITS       = P2_BITS + BOOST_BITS;
   localparam int OUT_SHIFT     = 40;
   localparam int RES_BITS      = P3_BITS - OUT_SHIFT;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 16;
   localparam int FRONT_STAGES  = 7;
   localparam int TAIL_STAGES   = 5;
   localparam int PIPE_DEPTH    = FRONT_STAGES + ROOT_BITS + QUO_BITS + TAIL_STAGES;

   localparam int FULL_LIGHT    = 256;
   localparam int HALF_LEVEL    = 32768;
   localparam int AO_ONE        = 65536;
   localparam int NUM_BIAS      = 128 * 2048;
   localparam int U_SQ          = 2048 * 2048;
   localparam int ROOT_MIN      = 32768;
   localparam longint RCP_ONE   = longint'(1) << AOX_BITS;

   localparam logic [CSR_IDX_BITS-1:0] CSR_LIGHT_X   = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LIGHT_Y   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_INTENSITY = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_STRENGTH  = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FLOOR     = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_THRESHOLD = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BOOST     = 3'd6;

   typedef struct packed {
      logic [RAD_BITS-1:0]        rad;
      logic [ROOT_BITS-1:0]       root;
      logic [SRM_BITS-1:0]        rem;
      logic signed [NUM_BITS-1:0] num;
      logic [AO_BITS-1:0]         ao;
      logic                       edge_hit;
   } sqrt_type;

   typedef struct packed {
      logic [QUO_BITS-1:0]  low;
      logic [DREM_BITS-1:0] rem;
      logic [QUO_BITS-1:0]  quo;
      logic [ROOT_BITS-1:0] dsr;
      logic                 neg;
      logic [AO_BITS-1:0]   ao;
      logic                 edge_hit;
   } div_type;

   // floor(2^AOX_BITS / count); one correction step after the multiply fixes it up
   function automatic logic [RCP_BITS-1:0] ao_recip(input logic [CNT_BITS-1:0] cnt);
      logic [RCP_BITS-1:0] rcp;
      case (cnt)
         4'd1:    rcp = RCP_BITS'(RCP_ONE);
         4'd2:    rcp = RCP_BITS'(RCP_ONE / 2);
         4'd3:    rcp = RCP_BITS'(RCP_ONE / 3);
         4'd4:    rcp = RCP_BITS'(RCP_ONE / 4);
         4'd5:    rcp = RCP_BITS'(RCP_ONE / 5);
         4'd6:    rcp = RCP_BITS'(RCP_ONE / 6);
         4'd7:    rcp = RCP_BITS'(RCP_ONE / 7);
         4'd8:    rcp = RCP_BITS'(RCP_ONE / 8);
         default: rcp = '0;
      endcase
      return rcp;
   endfunction

endpackage

// ===== rtl/heightmap_sobel_shading.sv =====
// Heightmap shading: one 3x3 window of heights in per cycle, one light level out
// per window, in order. An item is taken on every cycle that start is high (busy
// stays low) and its light level appears on rsp_light_level with rsp_valid high for
// one cycle once the item leaves the last stage. The pipeline is made of the square
// root of the gradient length (one result bit per stage, 23 stages) followed by the
// normalizing divide (one quotient bit per stage, 18 stages); seven stages ahead of
// them form the Sobel sums, products and the occlusion factor, five behind them
// form the intensity products and the clamp. The receiver has no way to stall the
// stream, so it must take every result in the cycle it is shown. Write the csr_
// registers only while no item is in flight.
module heightmap_sobel_shading
   import hss_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [HEIGHT_BITS-1:0]   req_center_height,
   input  logic [HEIGHT_BITS-1:0]   req_west_height,
   input  logic [HEIGHT_BITS-1:0]   req_east_height,
   input  logic [HEIGHT_BITS-1:0]   req_north_height,
   input  logic [HEIGHT_BITS-1:0]   req_south_height,
   input  logic [HEIGHT_BITS-1:0]   req_north_west_height,
   input  logic [HEIGHT_BITS-1:0]   req_north_east_height,
   input  logic [HEIGHT_BITS-1:0]   req_south_west_height,
   input  logic [HEIGHT_BITS-1:0]   req_south_east_height,
   output logic                     rsp_valid,
   output logic [LEVEL_BITS-1:0]    rsp_light_level,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   // configuration
   logic signed [LDIR_BITS-1:0] light_dir_x_ff;
   logic signed [LDIR_BITS-1:0] light_dir_y_ff;
   logic [INT_BITS-1:0]         light_intensity_ff;
   logic [STR_BITS-1:0]         occlusion_strength_ff;
   logic [FLOOR_BITS-1:0]       occlusion_floor_ff;
   logic [THR_BITS-1:0]         edge_threshold_ff;
   logic [BOOST_BITS-1:0]       edge_boost_ff;

   // valid bits
   logic [FRONT_STAGES-1:0] front_vld_ff;
   logic [ROOT_BITS-1:0]    sq_vld_ff;
   logic [QUO_BITS-1:0]     dv_vld_ff;
   logic [TAIL_STAGES-1:0]  tail_vld_ff;

   // stage 1: Sobel sums, positive differences
   logic signed [SOBEL_BITS-1:0]     sx1_in, sy1_in, sx1_ff, sy1_ff;
   logic [7:0][HEIGHT_BITS-1:0]      dpos1_in, dpos1_ff;
   logic [CNT_BITS-1:0]              cnt1_in, cnt1_ff;
   // stage 2: squares, light products, edge test, pair sums
   logic [SQR_BITS-1:0]              sqx2_in, sqy2_in, sqx2_ff, sqy2_ff;
   logic signed [PRD_BITS-1:0]       px2_in, py2_in, px2_ff, py2_ff;
   logic                             edge2_in, edge2_ff;
   logic [3:0][SUM_BITS-1:0]         psum2_in, psum2_ff;
   logic [CNT_BITS-1:0]              cnt2_ff;
   // stage 3: length squared, dot numerator, difference sum
   logic [SQ_BITS-1:0]               q3_in, q3_ff;
   logic signed [NUM_BITS-1:0]       num3_in, num3_ff;
   logic [SUM_BITS-1:0]              sum3_in, sum3_ff;
   logic                             edge3_ff;
   logic [CNT_BITS-1:0]              cnt3_ff;
   // stages 4 to 7: occlusion
   logic [AOX_BITS-1:0]              x4_in, x4_ff, x5_ff;
   logic [RPROD_BITS-1:0]            rprod5;
   logic [AOX_BITS-1:0]              qa5_in, qa5_ff;
   logic [AOX_BITS-1:0]              chk6, rem6;
   logic [AOX_BITS-1:0]              t6_in, t6_ff;
   logic signed [AOD_BITS-1:0]       diff7;
   logic [AO_BITS-1:0]               fl7;
   logic [AO_BITS-1:0]               ao7_in, ao7_ff;
   logic [CNT_BITS-1:0]              cnt4_ff, cnt5_ff, cnt6_ff;
   logic [SQ_BITS-1:0]               q4_ff, q5_ff, q6_ff, q7_ff;
   logic signed [NUM_BITS-1:0]       num4_ff, num5_ff, num6_ff, num7_ff;
   logic                             edge4_ff, edge5_ff, edge6_ff, edge7_ff;
   // square root and divide chains
   sqrt_type                         sq_seed;
   sqrt_type                         sq_in [ROOT_BITS];
   sqrt_type                         sq_ff [ROOT_BITS];
   div_type                          dv_seed;
   div_type                          dv_in [QUO_BITS];
   div_type                          dv_ff [QUO_BITS];
   logic [NUM_BITS-2:0]              nmag;
   logic [DVD_BITS-1:0]              dvd;
   // tail
   logic [QUO_BITS:0]                qmag;
   logic signed [LVLS_BITS-1:0]      lvls;
   logic [LVL_BITS-1:0]              lvl_in, lvl_ff;
   logic [AO_BITS-1:0]               lvl_ao_ff;
   logic                             lvl_edge_ff, p1_edge_ff, p2_edge_ff;
   logic [P1_BITS-1:0]               p1_in, p1_ff;
   logic [P2_BITS-1:0]               p2_in, p2_ff;
   logic [BOOST_BITS-1:0]            factor;
   logic [P3_BITS-1:0]               p3_in, p3_ff;
   logic [RES_BITS-1:0]              res;
   logic [LEVEL_BITS-1:0]            out_in, out_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         light_dir_x_ff        <= LDIR_BITS'(256);
         light_dir_y_ff        <= '0;
         light_intensity_ff    <= INT_BITS'(256);
         occlusion_strength_ff <= STR_BITS'(38);
         occlusion_floor_ff    <= FLOOR_BITS'(154);
         edge_threshold_ff     <= THR_BITS'(128);
         edge_boost_ff         <= BOOST_BITS'(282);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_LIGHT_X:   light_dir_x_ff        <= csr_wdata[LDIR_BITS-1:0];
            CSR_LIGHT_Y:   light_dir_y_ff        <= csr_wdata[LDIR_BITS-1:0];
            CSR_INTENSITY: light_intensity_ff    <= csr_wdata[INT_BITS-1:0];
            CSR_STRENGTH:  occlusion_strength_ff <= csr_wdata[STR_BITS-1:0];
            CSR_FLOOR:     occlusion_floor_ff    <= csr_wdata[FLOOR_BITS-1:0];
            CSR_THRESHOLD: edge_threshold_ff     <= csr_wdata[THR_BITS-1:0];
            CSR_BOOST:     edge_boost_ff         <= csr_wdata[BOOST_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_vld_ff <= '0;
         sq_vld_ff    <= '0;
         dv_vld_ff    <= '0;
         tail_vld_ff  <= '0;
      end else begin
         front_vld_ff <= {front_vld_ff[FRONT_STAGES-2:0], start};
         sq_vld_ff    <= {sq_vld_ff[ROOT_BITS-2:0], front_vld_ff[FRONT_STAGES-1]};
         dv_vld_ff    <= {dv_vld_ff[QUO_BITS-2:0], sq_vld_ff[ROOT_BITS-1]};
         tail_vld_ff  <= {tail_vld_ff[TAIL_STAGES-2:0], dv_vld_ff[QUO_BITS-1]};
      end
   end

   // stage 1
   always_comb begin
      logic [MAG_BITS-1:0] xp, xn, yp, yn;
      logic [7:0][HEIGHT_BITS-1:0] nb;
      xp = MAG_BITS'(req_north_east_height) + (MAG_BITS'(req_east_height) << 1)
         + MAG_BITS'(req_south_east_height);
      xn = MAG_BITS'(req_north_west_height) + (MAG_BITS'(req_west_height) << 1)
         + MAG_BITS'(req_south_west_height);
      yp = MAG_BITS'(req_south_west_height) + (MAG_BITS'(req_south_height) << 1)
         + MAG_BITS'(req_south_east_height);
      yn = MAG_BITS'(req_north_west_height) + (MAG_BITS'(req_north_height) << 1)
         + MAG_BITS'(req_north_east_height);
      sx1_in = $signed({1'b0, xp}) - $signed({1'b0, xn});
      sy1_in = $signed({1'b0, yp}) - $signed({1'b0, yn});
      nb = {req_south_east_height, req_south_west_height, req_north_east_height,
            req_north_west_height, req_south_height, req_north_height,
            req_east_height, req_west_height};
      cnt1_in = '0;
      for (int i = 0; i < 8; i++) begin
         if (req_center_height > nb[i]) begin
            dpos1_in[i] = req_center_height - nb[i];
            cnt1_in     = cnt1_in + CNT_BITS'(1);
         end else begin
            dpos1_in[i] = '0;
         end
      end
   end

   // stage 2
   always_comb begin
      logic [MAG_BITS-1:0] ax, ay;
      logic [CMP_BITS-1:0] thr8;
      ax = (sx1_ff < 0) ? MAG_BITS'(-sx1_ff) : MAG_BITS'(sx1_ff);
      ay = (sy1_ff < 0) ? MAG_BITS'(-sy1_ff) : MAG_BITS'(sy1_ff);
      thr8 = CMP_BITS'({edge_threshold_ff, 3'b000});
      edge2_in = (CMP_BITS'(ax) > thr8) || (CMP_BITS'(ay) > thr8);
      sqx2_in = SQR_BITS'(ax) * SQR_BITS'(ax);
      sqy2_in = SQR_BITS'(ay) * SQR_BITS'(ay);
      px2_in = PRD_BITS'(sx1_ff) * PRD_BITS'(light_dir_x_ff);
      py2_in = PRD_BITS'(sy1_ff) * PRD_BITS'(light_dir_y_ff);
      for (int j = 0; j < 4; j++) begin
         psum2_in[j] = SUM_BITS'(dpos1_ff[2*j]) + SUM_BITS'(dpos1_ff[2*j+1]);
      end
   end

   // stage 3
   assign q3_in   = SQ_BITS'(sqx2_ff) + SQ_BITS'(sqy2_ff) + SQ_BITS'(U_SQ);
   assign num3_in = NUM_BITS'(NUM_BIAS) - NUM_BITS'(px2_ff) - NUM_BITS'(py2_ff);
   assign sum3_in = psum2_ff[0] + psum2_ff[1] + psum2_ff[2] + psum2_ff[3];

   // stages 4 to 7: t = floor(sum * strength / count) through a reciprocal, then ao = 65536 - t held at the floor
   assign x4_in  = AOX_BITS'(sum3_ff) * AOX_BITS'(occlusion_strength_ff);
   assign rprod5 = RPROD_BITS'(x4_ff) * RPROD_BITS'(ao_recip(cnt4_ff));
   assign qa5_in = rprod5[2*AOX_BITS-1:AOX_BITS];
   assign chk6   = qa5_ff * AOX_BITS'(cnt5_ff);
   assign rem6   = x5_ff - chk6;
   // the estimate is low by at most one
   assign t6_in  = (rem6 >= AOX_BITS'(cnt5_ff)) ? qa5_ff + AOX_BITS'(1) : qa5_ff;
   assign diff7  = AOD_BITS'(AO_ONE) - $signed({2'b00, t6_ff});
   assign fl7    = {occlusion_floor_ff, 8'h00};

   always_comb begin
      if (cnt6_ff == '0) begin
         ao7_in = AO_BITS'(AO_ONE);
      end else if (diff7 < $signed({{(AOD_BITS-AO_BITS){1'b0}}, fl7})) begin
         ao7_in = fl7;
      end else begin
         ao7_in = diff7[AO_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      sx1_ff    <= sx1_in;
      sy1_ff    <= sy1_in;
      dpos1_ff  <= dpos1_in;
      cnt1_ff   <= cnt1_in;
      sqx2_ff   <= sqx2_in;
      sqy2_ff   <= sqy2_in;
      px2_ff    <= px2_in;
      py2_ff    <= py2_in;
      edge2_ff  <= edge2_in;
      psum2_ff  <= psum2_in;
      cnt2_ff   <= cnt1_ff;
      q3_ff     <= q3_in;
      num3_ff   <= num3_in;
      sum3_ff   <= sum3_in;
      edge3_ff  <= edge2_ff;
      cnt3_ff   <= cnt2_ff;
      x4_ff     <= x4_in;
      cnt4_ff   <= cnt3_ff;
      q4_ff     <= q3_ff;
      num4_ff   <= num3_ff;
      edge4_ff  <= edge3_ff;
      qa5_ff    <= qa5_in;
      x5_ff     <= x4_ff;
      cnt5_ff   <= cnt4_ff;
      q5_ff     <= q4_ff;
      num5_ff   <= num4_ff;
      edge5_ff  <= edge4_ff;
      t6_ff     <= t6_in;
      cnt6_ff   <= cnt5_ff;
      q6_ff     <= q5_ff;
      num6_ff   <= num5_ff;
      edge6_ff  <= edge5_ff;
      ao7_ff    <= ao7_in;
      q7_ff     <= q6_ff;
      num7_ff   <= num6_ff;
      edge7_ff  <= edge6_ff;
   end

   // square root of 256*Q, two radicand bits per stage
   always_comb begin
      sq_seed.rad      = {q7_ff, 8'h00};
      sq_seed.root     = '0;
      sq_seed.rem      = '0;
      sq_seed.num      = num7_ff;
      sq_seed.ao       = ao7_ff;
      sq_seed.edge_hit = edge7_ff;
   end

   always_comb begin
      sqrt_type            src;
      logic [SRM_BITS-1:0] rem2;
      logic [SRM_BITS-1:0] trial;
      logic                ge;
      for (int k = 0; k < ROOT_BITS; k++) begin
         if (k == 0) begin
            src = sq_seed;
         end else begin
            src = sq_ff[k-1];
         end
         rem2  = {src.rem[SRM_BITS-3:0], src.rad[RAD_BITS-1 -: 2]};
         trial = {src.root, 2'b01};
         ge    = rem2 >= trial;
         sq_in[k]      = src;
         sq_in[k].rem  = ge ? rem2 - trial : rem2;
         sq_in[k].root = {src.root[ROOT_BITS-2:0], ge};
         sq_in[k].rad  = {src.rad[RAD_BITS-3:0], 2'b00};
      end
   end

   // divide |num| * 2048 by the root, one quotient bit per stage
   always_comb begin
      nmag = (sq_ff[ROOT_BITS-1].num < 0) ? (NUM_BITS-1)'(-sq_ff[ROOT_BITS-1].num)
                                           : (NUM_BITS-1)'(sq_ff[ROOT_BITS-1].num);
      dvd = {nmag, {DIV_SHIFT{1'b0}}};
      dv_seed.low      = dvd[QUO_BITS-1:0];
      dv_seed.rem      = DREM_BITS'(dvd[DVD_BITS-1:QUO_BITS]);
      dv_seed.quo      = '0;
      dv_seed.dsr      = sq_ff[ROOT_BITS-1].root;
      dv_seed.neg      = sq_ff[ROOT_BITS-1].num < 0;
      dv_seed.ao       = sq_ff[ROOT_BITS-1].ao;
      dv_seed.edge_hit = sq_ff[ROOT_BITS-1].edge_hit;
   end

   always_comb begin
      div_type              src;
      logic [DREM_BITS-1:0] rem2;
      logic                 ge;
      for (int k = 0; k < QUO_BITS; k++) begin
         if (k == 0) begin
            src = dv_seed;
         end else begin
            src = dv_ff[k-1];
         end
         rem2 = {src.rem[DREM_BITS-2:0], src.low[QUO_BITS-1]};
         ge   = rem2 >= {1'b0, src.dsr};
         dv_in[k]     = src;
         dv_in[k].rem = ge ? rem2 - {1'b0, src.dsr} : rem2;
         dv_in[k].quo = {src.quo[QUO_BITS-2:0], ge};
         dv_in[k].low = {src.low[QUO_BITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < ROOT_BITS; k++) begin
         sq_ff[k] <= sq_in[k];
      end
      for (int k = 0; k < QUO_BITS; k++) begin
         dv_ff[k] <= dv_in[k];
      end
   end

   // floor division: round the magnitude up for a negative numerator
   always_comb begin
      qmag = {1'b0, dv_ff[QUO_BITS-1].quo}
           + (QUO_BITS+1)'(dv_ff[QUO_BITS-1].neg && (dv_ff[QUO_BITS-1].rem != '0));
      lvls = dv_ff[QUO_BITS-1].neg ? LVLS_BITS'(HALF_LEVEL) - $signed({1'b0, qmag})
                                   : LVLS_BITS'(HALF_LEVEL) + $signed({1'b0, qmag});
      lvl_in = (lvls > 0) ? lvls[LVL_BITS-1:0] : '0;
   end

   assign p1_in  = P1_BITS'(lvl_ff) * P1_BITS'(lvl_ao_ff);
   assign p2_in  = P2_BITS'(p1_ff) * P2_BITS'(light_intensity_ff);
   assign factor = p2_edge_ff ? edge_boost_ff : BOOST_BITS'(FULL_LIGHT);
   assign p3_in  = P3_BITS'(p2_ff) * P3_BITS'(factor);
   assign res    = p3_ff[P3_BITS-1:OUT_SHIFT];
   assign out_in = (res > RES_BITS'(FULL_LIGHT)) ? LEVEL_BITS'(FULL_LIGHT)
                                                 : res[LEVEL_BITS-1:0];

   always_ff @(posedge clock) begin
      lvl_ff      <= lvl_in;
      lvl_ao_ff   <= dv_ff[QUO_BITS-1].ao;
      lvl_edge_ff <= dv_ff[QUO_BITS-1].edge_hit;
      p1_ff       <= p1_in;
      p1_edge_ff  <= lvl_edge_ff;
      p2_ff       <= p2_in;
      p2_edge_ff  <= p1_edge_ff;
      p3_ff       <= p3_in;
      out_ff      <= out_in;
   end

   assign rsp_valid       = tail_vld_ff[TAIL_STAGES-1];
   assign rsp_light_level = out_ff;

`ifndef SYNTH
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##PIPE_DEPTH rsp_valid)
      else $error("item did not come out after the pipeline depth");
   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, PIPE_DEPTH))
      else $error("result without an accepted item");
   a_root_floor: assert property (@(posedge clock) disable iff (reset)
      dv_vld_ff[0] |-> dv_ff[0].dsr >= ROOT_BITS'(ROOT_MIN))
      else $error("square root below its lower bound");
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_light_level <= LEVEL_BITS'(FULL_LIGHT))
      else $error("light level above full light");
`endif

endmodule

// ===== test/tb_top.sv =====
module tb_top;
   import hss_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [HEIGHT_BITS-1:0] req_h [9] = '{default: '0};
   logic rsp_valid;
   logic [LEVEL_BITS-1:0] rsp_light_level;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   typedef struct {
      logic [HEIGHT_BITS-1:0] h [9];
   } window_type;

   window_type pending_items [$];
   logic [LEVEL_BITS-1:0] expected_levels [$];

   // shading settings mirrored from the register writes
   longint cfg_lx, cfg_ly, cfg_int, cfg_str, cfg_floor, cfg_thr, cfg_boost;

   int errors = 0;
   int accepted = 0;
   int checked = 0;
   int cycle_count = 0;
   int idle_pct = 32;
   localparam int CYCLE_LIMIT = 400000;

   heightmap_sobel_shading u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_center_height(req_h[0]), .req_west_height(req_h[1]),
      .req_east_height(req_h[2]), .req_north_height(req_h[3]),
      .req_south_height(req_h[4]), .req_north_west_height(req_h[5]),
      .req_north_east_height(req_h[6]), .req_south_west_height(req_h[7]),
      .req_south_east_height(req_h[8]),
      .rsp_valid(rsp_valid), .rsp_light_level(rsp_light_level),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic longint isqrt(longint v);
      longint res, b;
      res = 0;
      b = longint'(1) << 62;
      while (b > v) b = b >>> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >>> 1) + b;
         end else begin
            res = res >>> 1;
         end
         b = b >>> 2;
      end
      return res;
   endfunction

   function automatic logic [LEVEL_BITS-1:0] shade_level(window_type w);
      longint h [9];
      longint sx, sy, ax, ay, edge_f, u, q, r, num, lvl, sum, cnt, d, ao, t, res;
      for (int i = 0; i < 9; i++) h[i] = longint'(w.h[i]);
      sx = (h[6] + 2 * h[2] + h[8]) - (h[5] + 2 * h[1] + h[7]);
      sy = (h[7] + 2 * h[4] + h[8]) - (h[5] + 2 * h[3] + h[6]);
      ax = sx < 0 ? -sx : sx;
      ay = sy < 0 ? -sy : sy;
      edge_f = (ax > cfg_thr * 8 || ay > cfg_thr * 8) ? cfg_boost : 256;
      u = 2048;
      q = ax * ax + ay * ay + u * u;
      r = isqrt(q * 256);
      num = -sx * cfg_lx - sy * cfg_ly + 128 * u;
      lvl = 32768;
      if (r > 0) begin
         if (num >= 0) lvl += (num * 2048) / r;
         else lvl -= ((-num * 2048) + r - 1) / r;
      end
      sum = 0;
      cnt = 0;
      for (int i = 1; i < 9; i++) begin
         d = h[0] - h[i];
         if (d > 0) begin
            sum += d;
            cnt++;
         end
      end
      ao = 65536;
      if (cnt > 0) begin
         t = (sum * cfg_str) / cnt;
         ao = 65536 - t;
         if (ao < cfg_floor * 256) ao = cfg_floor * 256;
      end
      res = 0;
      if (lvl > 0) begin
         // product fits in 63 bits: 2^18 * 2^17 * 2^9 * 2^9
         res = (lvl * ao * cfg_int * edge_f) >>> 40;
         if (res > 256) res = 256;
      end
      return res[LEVEL_BITS-1:0];
   endfunction

   // driver: offer items at the falling edge, hold until accepted
   always @(negedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            void'(pending_items.pop_front());
         end
         if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
            for (int i = 0; i < 9; i++) req_h[i] <= pending_items[0].h[i];
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: predict on accept, compare each strobe with the oldest prediction
   always @(posedge clock) begin
      window_type w;
      cycle_count++;
      if (!reset) begin
         if (start && !busy) begin
            for (int i = 0; i < 9; i++) w.h[i] = req_h[i];
            expected_levels = {expected_levels, shade_level(w)};
            accepted++;
         end
         if (rsp_valid) begin
            if (expected_levels.size() == 0) begin
               $display("%0t: unexpected light level %0d", $time, rsp_light_level);
               errors++;
            end else begin
               if (rsp_light_level !== expected_levels[0]) begin
                  $display("%0t: light_level expected %0d actual %0d", $time,
                     expected_levels[0], rsp_light_level);
                  errors++;
               end
               void'(expected_levels.pop_front());
               checked++;
            end
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx, input longint val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CSR_DATA_BITS-1:0];
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_LIGHT_X:   cfg_lx = (val[9] ? longint'(val[9:0]) - 1024 : longint'(val[9:0]));
         CSR_LIGHT_Y:   cfg_ly = (val[9] ? longint'(val[9:0]) - 1024 : longint'(val[9:0]));
         CSR_INTENSITY: cfg_int = val & 'h1FF;
         CSR_STRENGTH:  cfg_str = val & 'hFF;
         CSR_FLOOR:     cfg_floor = val & 'h1FF;
         CSR_THRESHOLD: cfg_thr = val & 'hFFFF;
         CSR_BOOST:     cfg_boost = val & 'h1FF;
         default: ;
      endcase
   endtask

   task automatic drain;
      while (pending_items.size() > 0 || expected_levels.size() > 0) @(posedge clock);
      repeat (PIPE_DEPTH + 10) @(posedge clock);
   endtask

   task automatic push_window(input logic [HEIGHT_BITS-1:0] c,
                              input logic [HEIGHT_BITS-1:0] n [8]);
      window_type w;
      w.h[0] = c;
      for (int i = 0; i < 8; i++) w.h[i + 1] = n[i];
      pending_items = {pending_items, w};
   endtask

   task automatic push_random(input int count, input int mode);
      window_type w;
      logic [HEIGHT_BITS-1:0] base;
      for (int k = 0; k < count; k++) begin
         base = HEIGHT_BITS'($urandom);
         for (int i = 0; i < 9; i++) begin
            if (mode == 0 || $urandom_range(3) == 0) begin
               w.h[i] = HEIGHT_BITS'($urandom);
            end else begin
               // gentle terrain
               w.h[i] = HEIGHT_BITS'(32'(base) + $urandom_range(600) - 32'd300);
            end
            if ($urandom_range(15) == 0) w.h[i] = '0;          // outside the map
         end
         pending_items = {pending_items, w};
      end
   endtask

   task automatic random_settings;
      write_reg(CSR_LIGHT_X, longint'($urandom_range(512)) - 256);
      write_reg(CSR_LIGHT_Y, longint'($urandom_range(512)) - 256);
      write_reg(CSR_INTENSITY, longint'($urandom_range(511)));
      write_reg(CSR_STRENGTH, longint'($urandom_range(255)));
      write_reg(CSR_FLOOR, longint'($urandom_range(256)));
      write_reg(CSR_THRESHOLD, $urandom_range(3) == 0 ? longint'($urandom_range(65535))
                                                      : longint'($urandom_range(2000)));
      write_reg(CSR_BOOST, longint'($urandom_range(511)));
   endtask

   initial begin
      logic [HEIGHT_BITS-1:0] nb [8];
      cfg_lx = 256; cfg_ly = 0; cfg_int = 256; cfg_str = 38;
      cfg_floor = 154; cfg_thr = 128; cfg_boost = 282;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // flat, extremes, pits, peaks, steep ramps both ways, zero padding
      foreach (nb[i]) nb[i] = '0;
      push_window('0, nb);
      push_window('1, nb);
      foreach (nb[i]) nb[i] = '1;
      push_window('0, nb);
      push_window('1, nb);
      foreach (nb[i]) nb[i] = 16'h0100;
      push_window(16'h0100, nb);
      push_window(16'h0180, nb);
      nb = '{16'hFFFF, 0, 0, 0, 0, 16'hFFFF, 0, 16'hFFFF};
      push_window(16'h8000, nb);
      nb = '{0, 16'hFFFF, 0, 0, 16'hFFFF, 0, 16'hFFFF, 0};
      push_window(16'h8000, nb);
      nb = '{0, 0, 16'hFFFF, 0, 16'hFFFF, 16'hFFFF, 0, 0};
      push_window(16'h8000, nb);
      nb = '{0, 0, 0, 16'hFFFF, 0, 0, 16'hFFFF, 16'hFFFF};
      push_window(16'h8000, nb);
      nb = '{16'h00FF, 16'h0101, 16'h0100, 16'h0100, 16'h0100, 16'h0100, 16'h0100, 16'h0100};
      push_window(16'h0100, nb);
      push_random(8, 0);
      drain();

      // extreme settings with steep and gentle terrain
      write_reg(CSR_LIGHT_X, -256);
      write_reg(CSR_LIGHT_Y, 256);
      write_reg(CSR_INTENSITY, 511);
      write_reg(CSR_STRENGTH, 255);
      write_reg(CSR_FLOOR, 0);
      write_reg(CSR_THRESHOLD, 0);
      write_reg(CSR_BOOST, 511);
      push_random(80, 0);
      push_random(80, 1);
      drain();

      write_reg(CSR_LIGHT_X, 0);
      write_reg(CSR_LIGHT_Y, -256);
      write_reg(CSR_INTENSITY, 0);
      write_reg(CSR_STRENGTH, 0);
      write_reg(CSR_FLOOR, 256);
      write_reg(CSR_THRESHOLD, 65535);
      write_reg(CSR_BOOST, 0);
      push_random(40, 1);
      drain();
      write_reg(CSR_INTENSITY, 256);
      push_random(40, 0);
      drain();

      // back-to-back stretch with no idling
      random_settings();
      idle_pct = 0;
      push_random(150, 1);
      drain();
      idle_pct = 32;

      for (int p = 0; p < 6; p++) begin
         random_settings();
         push_random(50, 0);
         push_random(70, 1);
         drain();
      end

      $display("%0d windows shaded and %0d light levels checked", accepted, checked);
      $display("over flat, steep, padded and random terrain under extreme and random settings");
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
